FILE: hdl/kbd_sc2a_pkg.sv
package kbd_sc2a_pkg;

  typedef logic [7:0] scan_t;
  typedef logic [6:0] ascii_t;

  // Scan codes with special handling
  localparam scan_t CodeShiftPress   = 8'h2A;
  localparam scan_t CodeShiftRelease = 8'hAA;
  localparam scan_t CodeEnter        = 8'h1C;
  localparam int    ReleaseBit       = 7;

  localparam ascii_t AsciiCr   = 7'h0D;
  localparam ascii_t AsciiLf   = 7'h0A;
  localparam ascii_t AsciiNone = 7'h00;

  // Channel payloads
  typedef struct packed {
    scan_t scan_code;
  } scan_item_t;

  typedef struct packed {
    ascii_t ascii_char;
    logic   last_of_run;
  } char_item_t;

  // US layout, no shift; zero means no character on this key
  function automatic logic [7:0] plain_map(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = "1";
      7'h03: ch = "2";
      7'h04: ch = "3";
      7'h05: ch = "4";
      7'h06: ch = "5";
      7'h07: ch = "6";
      7'h08: ch = "7";
      7'h09: ch = "8";
      7'h0a: ch = "9";
      7'h0b: ch = "0";
      7'h0c: ch = "-";
      7'h0d: ch = "=";
      7'h10: ch = "q";
      7'h11: ch = "w";
      7'h12: ch = "e";
      7'h13: ch = "r";
      7'h14: ch = "t";
      7'h15: ch = "y";
      7'h16: ch = "u";
      7'h17: ch = "i";
      7'h18: ch = "o";
      7'h19: ch = "p";
      7'h1a: ch = "[";
      7'h1b: ch = "]";
      7'h1e: ch = "a";
      7'h1f: ch = "s";
      7'h20: ch = "d";
      7'h21: ch = "f";
      7'h22: ch = "g";
      7'h23: ch = "h";
      7'h24: ch = "j";
      7'h25: ch = "k";
      7'h26: ch = "l";
      7'h27: ch = ";";
      7'h28: ch = "'";
      7'h2b: ch = "\\";
      7'h2c: ch = "z";
      7'h2d: ch = "x";
      7'h2e: ch = "c";
      7'h2f: ch = "v";
      7'h30: ch = "b";
      7'h31: ch = "n";
      7'h32: ch = "m";
      7'h33: ch = ",";
      7'h34: ch = ".";
      7'h35: ch = "/";
      7'h39: ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // US layout with shift held
  function automatic logic [7:0] shifted_map(input logic [6:0] code);
    logic [7:0] ch;
    case (code)
      7'h02: ch = "!";
      7'h03: ch = "@";
      7'h04: ch = "#";
      7'h05: ch = "$";
      7'h06: ch = "%";
      7'h07: ch = "^";
      7'h08: ch = "&";
      7'h09: ch = "*";
      7'h0a: ch = "(";
      7'h0b: ch = ")";
      7'h0c: ch = "_";
      7'h0d: ch = "+";
      7'h10: ch = "Q";
      7'h11: ch = "W";
      7'h12: ch = "E";
      7'h13: ch = "R";
      7'h14: ch = "T";
      7'h15: ch = "Y";
      7'h16: ch = "U";
      7'h17: ch = "I";
      7'h18: ch = "O";
      7'h19: ch = "P";
      7'h1a: ch = "{";
      7'h1b: ch = "}";
      7'h1e: ch = "A";
      7'h1f: ch = "S";
      7'h20: ch = "D";
      7'h21: ch = "F";
      7'h22: ch = "G";
      7'h23: ch = "H";
      7'h24: ch = "J";
      7'h25: ch = "K";
      7'h26: ch = "L";
      7'h27: ch = ":";
      7'h28: ch = "\"";
      7'h2b: ch = "|";
      7'h2c: ch = "Z";
      7'h2d: ch = "X";
      7'h2e: ch = "C";
      7'h2f: ch = "V";
      7'h30: ch = "B";
      7'h31: ch = "N";
      7'h32: ch = "M";
      7'h33: ch = "<";
      7'h34: ch = ">";
      7'h35: ch = "?";
      7'h39: ch = " ";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic ascii_t map_char(input logic shift, input logic [6:0] code);
    logic [7:0] ch;
    ch = shift ? shifted_map(code) : plain_map(code);
    return ch[6:0];
  endfunction

endpackage

FILE: hdl/kbd_sc2a_stream_if.sv
interface kbd_sc2a_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/keyboard_scancode_to_ascii.sv
// A scan code transfer loads the decode stage; its result then goes to the
// result register. One scan code per cycle unless the result register
// stalls; Enter stays until CR then LF pass the single result register.
// Shift press/release, other releases and unmapped codes give no result.
// Reset (rst_ni low, asynchronous) empties both stages and clears shift.
module keyboard_scancode_to_ascii (
  input  logic clk_i,
  input  logic rst_ni,
  kbd_sc2a_stream_if.sink   scan_i,
  kbd_sc2a_stream_if.source char_o
);
  import kbd_sc2a_pkg::*;

  // Decode stage: captured code plus the shift state seen at transfer
  logic   s1_valid_q, s1_valid_d;
  scan_t  s1_code_q;
  logic   s1_shift_q;
  logic   s1_phase_q, s1_phase_d;   // Enter: 0 = CR pending, 1 = LF pending
  logic   shift_q, shift_d;

  // Result register
  logic   out_valid_q, out_valid_d;
  ascii_t out_char_q;
  logic   out_last_q;

  logic   in_xfer;
  logic   out_free;
  logic   is_enter;
  logic   has_result;
  logic   s1_done;
  logic   out_load;
  ascii_t dec_char;
  ascii_t res_char;
  logic   res_last;

  assign in_xfer  = scan_i.valid && scan_i.ready;
  assign out_free = !out_valid_q || char_o.ready;

  // Character decode of the held code
  assign dec_char = map_char(s1_shift_q, s1_code_q[6:0]);
  assign is_enter = (s1_code_q == CodeEnter);

  always_comb begin
    has_result = 1'b0;
    res_char   = dec_char;
    res_last   = 1'b1;
    if (!s1_code_q[ReleaseBit]) begin
      if (is_enter) begin
        has_result = 1'b1;
        res_char   = s1_phase_q ? AsciiLf : AsciiCr;
        res_last   = s1_phase_q;
      end else begin
        has_result = (dec_char != AsciiNone);
      end
    end
  end

  // Stage handoff: an item leaves once its last result is loaded, or when it gives no result
  assign out_load = s1_valid_q && has_result && out_free;
  assign s1_done  = s1_valid_q && (!has_result || (out_free && res_last));
  assign scan_i.ready = !s1_valid_q || s1_done;

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_phase_d = s1_phase_q;
    if (s1_done) begin
      s1_valid_d = 1'b0;
    end
    if (out_load && !res_last) begin
      s1_phase_d = 1'b1;
    end
    if (in_xfer) begin
      s1_valid_d = 1'b1;
      s1_phase_d = 1'b0;
    end
  end

  // Left shift tracking at input transfer
  always_comb begin
    shift_d = shift_q;
    if (in_xfer) begin
      if (scan_i.data.scan_code == CodeShiftPress) begin
        shift_d = 1'b1;
      end else if (scan_i.data.scan_code == CodeShiftRelease) begin
        shift_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (char_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_phase_q  <= 1'b0;
      shift_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s1_phase_q  <= s1_phase_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_code_q  <= scan_i.data.scan_code;
      s1_shift_q <= shift_q;
    end
    if (out_load) begin
      out_char_q <= res_char;
      out_last_q <= res_last;
    end
  end

  assign char_o.valid            = out_valid_q;
  assign char_o.data.ascii_char  = out_char_q;
  assign char_o.data.last_of_run = out_last_q;

endmodule
